@@ src/bcd_pkg.sv @@
package bcd_pkg;

  localparam int unsigned TIMER_BITS = 32;
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 16;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_CLICK  = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    PH_NONE = 2'd0,
    PH_DOWN = 2'd1,
    PH_UP   = 2'd2
  } phase_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DEBOUNCE = 3'd0,
    REG_LONG     = 3'd1,
    REG_WINDOW   = 3'd2,
    REG_ACTIVE   = 3'd3,
    REG_ENABLE   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  debounce_ticks;
    logic [15:0] long_press_ticks;
    logic [15:0] double_window_ticks;
    logic        active_level;
    logic [2:0]  event_enable;
  } cfg_t;

  typedef struct packed {
    event_e event_code;
    logic   stable_level;
    phase_e press_state;
  } result_t;

endpackage

@@ src/bcd_cfg.sv @@
module bcd_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bcd_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [bcd_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  output bcd_pkg::cfg_t                      cfg_o
);

  bcd_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        bcd_pkg::REG_DEBOUNCE: cfg_d.debounce_ticks      = cfg_data_i[7:0];
        bcd_pkg::REG_LONG:     cfg_d.long_press_ticks    = cfg_data_i;
        bcd_pkg::REG_WINDOW:   cfg_d.double_window_ticks = cfg_data_i;
        bcd_pkg::REG_ACTIVE:   cfg_d.active_level        = cfg_data_i[0];
        bcd_pkg::REG_ENABLE:   cfg_d.event_enable        = cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks      <= 8'd2;
      cfg_q.long_press_ticks    <= 16'd50;
      cfg_q.double_window_ticks <= 16'd15;
      cfg_q.active_level        <= 1'b0;
      cfg_q.event_enable        <= 3'd7;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ src/bcd_tracker.sv @@
module bcd_tracker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              level_i,
  input  bcd_pkg::cfg_t     cfg_i,
  output bcd_pkg::result_t  result_o
);

  localparam int unsigned TB = bcd_pkg::TIMER_BITS;

  logic              deb_q, deb_d;
  bcd_pkg::phase_e   phase_q, phase_d;
  bcd_pkg::phase_e   prev_q, prev_d;
  logic [7:0]        gc_q, gc_d;
  logic [TB-1:0]     timer_q, timer_d;
  logic [7:0]        rc_q, rc_d;
  bcd_pkg::event_e   pend_q, pend_d;
  bcd_pkg::event_e   code;
  logic [1:0]        sel;

  always_comb begin
    deb_d   = deb_q;
    phase_d = phase_q;
    gc_d    = gc_q;
    timer_d = timer_q;
    rc_d    = rc_q;
    pend_d  = pend_q;
    code    = bcd_pkg::EV_NONE;
    sel     = 2'd0;

    if (level_i != deb_q) begin
      if (gc_q != 8'hff) gc_d = gc_q + 8'd1;
      if (gc_d >= cfg_i.debounce_ticks) begin
        deb_d = level_i;
        gc_d  = 8'd0;
        if (level_i == cfg_i.active_level) begin
          phase_d = bcd_pkg::PH_DOWN;
          timer_d = '0;
        end else begin
          phase_d = bcd_pkg::PH_UP;
        end
      end
    end

    timer_d = timer_d + {{(TB-1){1'b0}}, 1'b1};

    case (phase_d)
      bcd_pkg::PH_DOWN: begin
        if (timer_d > {{(TB-16){1'b0}}, cfg_i.long_press_ticks} && deb_d == level_i
            && timer_d[1:0] == 2'b00) begin
          pend_d = bcd_pkg::EV_LONG;
        end
      end
      bcd_pkg::PH_UP: begin
        if (pend_d == bcd_pkg::EV_LONG) pend_d = bcd_pkg::EV_NONE;
        if (timer_d < {{(TB-16){1'b0}}, cfg_i.double_window_ticks}
            && prev_q == bcd_pkg::PH_DOWN) begin
          if (rc_d != 8'hff) rc_d = rc_d + 8'd1;
          timer_d = '0;
        end
        if (timer_d > {{(TB-16){1'b0}}, cfg_i.double_window_ticks}) begin
          if (rc_d == 8'd1) pend_d = bcd_pkg::EV_CLICK;
          else if (rc_d > 8'd1) pend_d = bcd_pkg::EV_DOUBLE;
          rc_d    = 8'd0;
          timer_d = '0;
        end
      end
      default: ;
    endcase

    prev_d = phase_d;

    // reported only when enabled, otherwise kept pending
    sel = pend_d - 2'd1;
    if (pend_d != bcd_pkg::EV_NONE && cfg_i.event_enable[sel]) begin
      code   = pend_d;
      pend_d = bcd_pkg::EV_NONE;
    end
  end

  assign result_o.event_code   = code;
  assign result_o.stable_level = deb_d;
  assign result_o.press_state  = phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q   <= 1'b1;
      phase_q <= bcd_pkg::PH_NONE;
      prev_q  <= bcd_pkg::PH_NONE;
      gc_q    <= 8'd0;
      timer_q <= '0;
      rc_q    <= 8'd0;
      pend_q  <= bcd_pkg::EV_NONE;
    end else if (step_i) begin
      deb_q   <= deb_d;
      phase_q <= phase_d;
      prev_q  <= prev_d;
      gc_q    <= gc_d;
      timer_q <= timer_d;
      rc_q    <= rc_d;
      pend_q  <= pend_d;
    end
  end

  a_no_long_when_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_d == bcd_pkg::PH_UP |-> pend_d != bcd_pkg::EV_LONG)
    else $error("long event kept after release");

  a_accept_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && deb_d != deb_q |-> gc_d == 8'd0)
    else $error("debounce count not cleared on accepted change");

  a_report_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    code != bcd_pkg::EV_NONE |-> cfg_i.event_enable[code - 2'd1])
    else $error("disabled event reported");

  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(phase_q) && $stable(timer_q))
    else $error("state moved without a word");

endmodule

@@ src/button_click_detector.sv @@
// Debounce and click classifier for one push button. Each input word is one
// tick carrying the raw pin level and gives exactly one result word: the event
// (none, click, double click, long click), the debounced level and the press
// phase. One word is taken every cycle while the input is not stalled; a result is
// offered once its word has passed the input register and the tracker's state
// update has filled the output register.
// Configuration writes are always ready and should only be issued while no
// words are in flight.
module button_click_detector (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bcd_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [bcd_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               raw_level_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         event_code_o,
  output logic                               stable_level_o,
  output logic [1:0]                         press_state_o
);

  bcd_pkg::cfg_t    cfg;
  bcd_pkg::result_t result;
  bcd_pkg::result_t res_q;

  logic s1_valid_q;
  logic s1_level_q;
  logic out_valid_q;
  logic s1_adv;

  // output register frees up when empty or taken this cycle
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;

  bcd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bcd_tracker u_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_adv),
    .level_i  (s1_level_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) s1_valid_q <= 1'b1;
      else if (s1_adv) s1_valid_q <= 1'b0;
      if (s1_adv) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) s1_level_q <= raw_level_i;
    if (s1_adv) res_q <= result;
  end

  assign out_valid_o    = out_valid_q;
  assign event_code_o   = res_q.event_code;
  assign stable_level_o = res_q.stable_level;
  assign press_state_o  = res_q.press_state;

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled with room downstream");

  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("advanced word lost");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(res_q))
    else $error("stalled result changed");

endmodule

@@ tb/bcd_checker.sv @@
module bcd_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [bcd_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [bcd_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic                               raw_level_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic [1:0]                         event_code_i,
  input  logic                               stable_level_i,
  input  logic [1:0]                         press_state_i,
  output int                                 fail_count_o,
  output int                                 pending_o,
  output int                                 words_checked_o,
  output int                                 clicks_o,
  output int                                 doubles_o,
  output int                                 longs_o
);

  localparam int unsigned TB = bcd_pkg::TIMER_BITS;

  bcd_pkg::cfg_t    cfg;
  logic             deb_level;
  bcd_pkg::phase_e  phase;
  bcd_pkg::phase_e  prev_phase;
  logic [7:0]       glitch_cnt;
  logic [TB-1:0]    timer;
  logic [7:0]       release_cnt;
  bcd_pkg::event_e  pend;

  bcd_pkg::result_t expected_words[$];

  task automatic report_mismatch(input string msg);
    if (fail_count_o < 100) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    fail_count_o++;
  endtask

  // one tick of the debounce and click classifier
  task automatic classify_tick(input logic lvl, output bcd_pkg::result_t word);
    bcd_pkg::event_e code;
    logic            fire;
    code = bcd_pkg::EV_NONE;
    fire = 1'b0;
    if (lvl != deb_level) begin
      if (glitch_cnt != 8'hff) begin
        glitch_cnt++;
      end
      if (glitch_cnt >= cfg.debounce_ticks) begin
        deb_level  = lvl;
        glitch_cnt = '0;
        if (lvl == cfg.active_level) begin
          phase = bcd_pkg::PH_DOWN;
          timer = '0;
        end else begin
          phase = bcd_pkg::PH_UP;
        end
      end
    end
    timer = timer + {{(TB-1){1'b0}}, 1'b1};
    if (phase == bcd_pkg::PH_DOWN) begin
      if (timer > {{(TB-16){1'b0}}, cfg.long_press_ticks} && deb_level == lvl
          && timer[1:0] == 2'b00) begin
        pend = bcd_pkg::EV_LONG;
      end
    end else if (phase == bcd_pkg::PH_UP) begin
      if (pend == bcd_pkg::EV_LONG) begin
        pend = bcd_pkg::EV_NONE;
      end
      if (timer < {{(TB-16){1'b0}}, cfg.double_window_ticks}
          && prev_phase == bcd_pkg::PH_DOWN) begin
        if (release_cnt != 8'hff) begin
          release_cnt++;
        end
        timer = '0;
      end
      if (timer > {{(TB-16){1'b0}}, cfg.double_window_ticks}) begin
        if (release_cnt == 8'd1) begin
          pend = bcd_pkg::EV_CLICK;
        end else if (release_cnt > 8'd1) begin
          pend = bcd_pkg::EV_DOUBLE;
        end
        release_cnt = '0;
        timer       = '0;
      end
    end
    prev_phase = phase;
    case (pend)
      bcd_pkg::EV_CLICK:  fire = cfg.event_enable[0];
      bcd_pkg::EV_DOUBLE: fire = cfg.event_enable[1];
      bcd_pkg::EV_LONG:   fire = cfg.event_enable[2];
      default:            fire = 1'b0;
    endcase
    if (fire) begin
      code = pend;
      pend = bcd_pkg::EV_NONE;
    end
    word.event_code   = code;
    word.stable_level = deb_level;
    word.press_state  = phase;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    bcd_pkg::result_t got;
    bcd_pkg::result_t want;
    bcd_pkg::result_t next_word;
    if (!rst_ni) begin
      cfg             = '{8'd2, 16'd50, 16'd15, 1'b0, 3'd7};
      deb_level       = ~cfg.active_level;
      phase           = bcd_pkg::PH_NONE;
      prev_phase      = bcd_pkg::PH_NONE;
      glitch_cnt      = '0;
      timer           = '0;
      release_cnt     = '0;
      pend            = bcd_pkg::EV_NONE;
      expected_words  = {};
      fail_count_o    = 0;
      pending_o       = 0;
      words_checked_o = 0;
      clicks_o        = 0;
      doubles_o       = 0;
      longs_o         = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          bcd_pkg::REG_DEBOUNCE: cfg.debounce_ticks      = cfg_data_i[7:0];
          bcd_pkg::REG_LONG:     cfg.long_press_ticks    = cfg_data_i;
          bcd_pkg::REG_WINDOW:   cfg.double_window_ticks = cfg_data_i;
          bcd_pkg::REG_ACTIVE:   cfg.active_level        = cfg_data_i[0];
          bcd_pkg::REG_ENABLE:   cfg.event_enable        = cfg_data_i[2:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        got.event_code   = bcd_pkg::event_e'(event_code_i);
        got.stable_level = stable_level_i;
        got.press_state  = bcd_pkg::phase_e'(press_state_i);
        words_checked_o++;
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf(
            "result word with none expected: event %0d level %0b phase %0d",
            event_code_i, stable_level_i, press_state_i));
        end else begin
          want = expected_words.pop_front();
          if (got.event_code !== want.event_code ||
              got.stable_level !== want.stable_level ||
              got.press_state !== want.press_state) begin
            report_mismatch($sformatf(
              "word %0d: event %0d/%0d level %0b/%0b phase %0d/%0d (got/exp)",
              words_checked_o, event_code_i, want.event_code,
              stable_level_i, want.stable_level,
              press_state_i, want.press_state));
          end
          case (want.event_code)
            bcd_pkg::EV_CLICK:  clicks_o++;
            bcd_pkg::EV_DOUBLE: doubles_o++;
            bcd_pkg::EV_LONG:   longs_o++;
            default: ;
          endcase
        end
      end
      if (in_valid_i && !in_stall_i) begin
        classify_tick(raw_level_i, next_word);
        expected_words.push_back(next_word);
      end
      pending_o = expected_words.size();
    end
  end

endmodule

@@ tb/tb_button_click_detector.sv @@
module tb_button_click_detector;

  localparam int LONG_HOLD_CYCLES = 300;

  logic                               clk_i = 1'b0;
  logic                               rst_ni;
  logic                               cfg_valid_i;
  logic                               cfg_ready_o;
  logic [bcd_pkg::CFG_IDX_BITS-1:0]   cfg_index_i;
  logic [bcd_pkg::CFG_DATA_BITS-1:0]  cfg_data_i;
  logic                               in_valid_i;
  logic                               in_stall_o;
  logic                               raw_level_i;
  logic                               out_valid_o;
  logic                               out_stall_i;
  logic [1:0]                         event_code_o;
  logic                               stable_level_o;
  logic [1:0]                         press_state_o;

  int fail_count;
  int pending_words;
  int words_checked;
  int clicks_seen;
  int doubles_seen;
  int longs_seen;

  logic act_lvl;
  int   cur_deb;
  int   cur_lng;
  int   cur_win;
  int   ticks_sent;
  int   settings_used;
  bit   src_idle_en;
  bit   snk_idle_en;
  bit   hold_req;

  always #10 clk_i = ~clk_i;

  button_click_detector dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .raw_level_i    (raw_level_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_code_o   (event_code_o),
    .stable_level_o (stable_level_o),
    .press_state_o  (press_state_o)
  );

  bcd_checker u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .raw_level_i     (raw_level_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .event_code_i    (event_code_o),
    .stable_level_i  (stable_level_o),
    .press_state_i   (press_state_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending_words),
    .words_checked_o (words_checked),
    .clicks_o        (clicks_seen),
    .doubles_o       (doubles_seen),
    .longs_o         (longs_seen)
  );

  task automatic send_tick(input logic lvl);
    int gap;
    if (src_idle_en && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    raw_level_i <= lvl;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ticks_sent++;
  endtask

  task automatic send_pattern(input logic [63:0] bits, input int n);
    int i;
    for (i = n - 1; i >= 0; i--) begin
      send_tick(bits[i]);
    end
  endtask

  // wait until every word in flight has come out
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_words != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [bcd_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_config(input int deb, input int lng, input int win, input int act,
                              input int en);
    logic [31:0] r;
    settle();
    r = $urandom;
    write_reg(bcd_pkg::REG_DEBOUNCE, {r[7:0], deb[7:0]});
    write_reg(bcd_pkg::REG_LONG, lng[15:0]);
    write_reg(bcd_pkg::REG_WINDOW, win[15:0]);
    write_reg(bcd_pkg::REG_ACTIVE, {r[22:8], act[0]});
    write_reg(bcd_pkg::REG_ENABLE, {r[31:19], en[2:0]});
    act_lvl = act[0];
    cur_deb = deb;
    cur_lng = lng;
    cur_win = win;
    settings_used++;
  endtask

  task automatic press(input int hold, input int rest, input int bounce);
    int i;
    for (i = 0; i < bounce; i++) send_tick(i[0] ? ~act_lvl : act_lvl);
    for (i = 0; i < hold; i++) send_tick(act_lvl);
    for (i = 0; i < bounce; i++) send_tick(i[0] ? act_lvl : ~act_lvl);
    for (i = 0; i < rest; i++) send_tick(~act_lvl);
  endtask

  task automatic run_presses(input int n);
    int k;
    int i;
    int hold;
    int rest;
    int kind;
    for (k = 0; k < n; k++) begin
      kind = $urandom_range(0, 9);
      hold = cur_deb + $urandom_range(0, 4);
      if (kind >= 5 && kind <= 6 && cur_lng <= 100) begin
        hold = cur_deb + cur_lng + $urandom_range(1, 20);
      end
      if ($urandom_range(0, 1) == 0 || cur_win > 200) begin
        rest = cur_deb + $urandom_range(0, 3);
      end else begin
        rest = cur_deb + cur_win + $urandom_range(1, 5);
      end
      if (kind == 7) begin
        for (i = 0; i < $urandom_range(3, 15); i++) send_tick(1'($urandom_range(0, 1)));
      end else begin
        press(hold, rest, (kind >= 8) ? $urandom_range(1, 3) : 0);
      end
    end
  endtask

  task automatic random_phase(input int presses);
    int deb;
    int lng;
    int win;
    int en;
    case ($urandom_range(0, 9))
      0:       deb = 0;
      7, 8:    deb = $urandom_range(4, 8);
      9:       deb = $urandom_range(9, 20);
      default: deb = $urandom_range(1, 3);
    endcase
    lng = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 40);
    win = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 30);
    en  = ($urandom_range(0, 1) == 0) ? 7 : $urandom_range(0, 7);
    apply_config(deb, lng, win, $urandom_range(0, 1), en);
    run_presses(presses);
  endtask

  // receiver side: random stall bursts and the long hold-off
  initial begin : sink_drive
    int n;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (snk_idle_en && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 10);
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    #(20 * 400000);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int p;
    int i;
    int drain;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    raw_level_i   = 1'b1;
    act_lvl       = 1'b0;
    cur_deb       = 2;
    cur_lng       = 50;
    cur_win       = 15;
    ticks_sent    = 0;
    settings_used = 0;
    src_idle_en   = 1'b1;
    snk_idle_en   = 1'b1;
    hold_req      = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // zero debounce, immediate long event, click and double click
    apply_config(0, 0, 3, 0, 7);
    send_pattern(64'b1_0000_1_01_1111_0101_1111, 20);
    // active level flipped while the debounced level stays, glitches not cleared
    apply_config(3, 65535, 65535, 1, 0);
    send_pattern(64'b0101_0110_0000, 12);
    // long event masked then dropped on release, masked click released later
    apply_config(1, 2, 4, 0, 3);
    press(12, 8, 0);
    apply_config(1, 60, 4, 0, 0);
    press(1, 8, 0);
    apply_config(1, 60, 4, 0, 1);
    send_pattern(64'b11, 2);

    settle();
    for (i = 5; i < 8; i++) write_reg(i[bcd_pkg::CFG_IDX_BITS-1:0], 16'($urandom));

    p = 0;
    while (ticks_sent < 1700) begin
      case (p)
        2: begin
          // release count runs into saturation
          apply_config(1, 65535, 40, $urandom_range(0, 1), 7);
          for (i = 0; i < 270; i++) begin
            send_tick(act_lvl);
            send_tick(~act_lvl);
          end
          press(0, 45, 0);
        end
        3: begin
          random_phase(0);
          hold_req = 1'b1;
          run_presses(10);
        end
        4: begin
          apply_config(255, $urandom_range(0, 20), $urandom_range(1, 20),
                       $urandom_range(0, 1), 7);
          for (i = 0; i < 20; i++) send_tick(1'($urandom_range(0, 1)));
          press(270, 270, 2);
        end
        5: begin
          apply_config($urandom_range(1, 2), $urandom_range(0, 30), 65535,
                       $urandom_range(0, 1), 7);
          run_presses(6);
        end
        default: random_phase($urandom_range(4, 12));
      endcase
      p++;
    end

    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    random_phase(12);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    drain = 0;
    while (pending_words != 0 && drain < 5000) begin
      @(negedge clk_i);
      drain++;
    end
    repeat (10) @(negedge clk_i);

    $display("run covered %0d ticks under %0d register settings, %0d result words checked",
             ticks_sent, settings_used, words_checked);
    $display("events seen: %0d click, %0d double click, %0d long click",
             clicks_seen, doubles_seen, longs_seen);
    if (fail_count == 0 && pending_words == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
